/* src/r2fft_pkg.sv */
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared types, constants and helper functions for the radix-2 FFT core.
// ----------------------------------------------------------------------------
package r2fft_pkg;

   localparam int LOG2_MAX_POINTS = 6;
   localparam int MAX_POINTS      = 1 << LOG2_MAX_POINTS;
   localparam int SAMPLE_WIDTH    = 16;
   localparam int WORK_WIDTH      = SAMPLE_WIDTH + 8;
   localparam int ADDR_WIDTH      = LOG2_MAX_POINTS;
   localparam int TW_WIDTH        = 17;
   localparam int LG_WIDTH        = 3;
   localparam int CSR_IDX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH  = 3;
   localparam logic signed [TW_WIDTH-1:0] HALF_ROOT2_Q15 = 17'sd23170;
   localparam logic signed [TW_WIDTH-1:0] ONE_Q15        = 17'sd32768;

   // Configuration register indexes.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_INVERSE     = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LOG2_POINTS = 2'd1;

   // Quarter-wave cosine table, Q2.15 with 1.0 = 32768.
   localparam logic signed [TW_WIDTH-1:0] COS_ROM [0:16] = '{
      17'sd32768, 17'sd32610, 17'sd32138, 17'sd31357, 17'sd30274, 17'sd28899,
      17'sd27246, 17'sd25330, 17'sd23170, 17'sd20788, 17'sd18205, 17'sd15447,
      17'sd12540, 17'sd9512,  17'sd6393,  17'sd3212,  17'sd0
   };

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] in_re;
      logic signed [SAMPLE_WIDTH-1:0] in_im;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] out_re;
      logic signed [SAMPLE_WIDTH-1:0] out_im;
      logic [ADDR_WIDTH-1:0]          bin_index;
      logic                           last_bin;
   } rsp_type;

   typedef struct packed {
      logic signed [WORK_WIDTH-1:0] re;
      logic signed [WORK_WIDTH-1:0] im;
   } work_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SWAP_RD,
      ST_SWAP_W1,
      ST_SWAP_W2,
      ST_BF_RD,
      ST_BF_MUL,
      ST_BF_SUM,
      ST_BF_ADD,
      ST_BF_WI,
      ST_BF_WJ,
      ST_EMIT,
      ST_DRAIN
   } state_type;

   // Cosine of 2*pi*t/64 from the quarter-wave table.
   function automatic logic signed [TW_WIDTH-1:0] tw_cos(input logic [5:0] t);
      logic signed [TW_WIDTH-1:0] r;
      if (t <= 6'd16) begin
         r = COS_ROM[t[4:0]];
      end else if (t <= 6'd32) begin
         r = -COS_ROM[5'(6'd32 - t)];
      end else if (t <= 6'd48) begin
         r = -COS_ROM[5'(t - 6'd32)];
      end else begin
         r = COS_ROM[5'(7'd64 - {1'b0, t})];
      end
      return r;
   endfunction

   function automatic logic signed [TW_WIDTH-1:0] tw_sin(input logic [5:0] t);
      return tw_cos(t + 6'd48);
   endfunction

   // Reverse the low lg bits of an address.
   function automatic logic [ADDR_WIDTH-1:0] bit_rev(input logic [ADDR_WIDTH-1:0] v,
                                                    input logic [LG_WIDTH-1:0] lg);
      logic [ADDR_WIDTH-1:0] r;
      for (int b = 0; b < ADDR_WIDTH; b++) begin
         r[ADDR_WIDTH-1-b] = v[b];
      end
      return r >> (3'(ADDR_WIDTH) - lg);
   endfunction

endpackage

/* src/r2fft_ram.sv */
// ----------------------------------------------------------------------------
// r2fft_ram
// Working store: one write port and two read ports with registered data.
// ----------------------------------------------------------------------------
module r2fft_ram #(
   parameter int ADDR_WIDTH = 6,
   parameter int DATA_WIDTH = 48
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [ADDR_WIDTH-1:0] waddr,
   input  logic [DATA_WIDTH-1:0] wdata,
   input  logic [ADDR_WIDTH-1:0] raddr_a,
   input  logic [ADDR_WIDTH-1:0] raddr_b,
   output logic [DATA_WIDTH-1:0] rdata_a,
   output logic [DATA_WIDTH-1:0] rdata_b
);

   logic [DATA_WIDTH-1:0] mem [0:(1 << ADDR_WIDTH)-1];

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read ports.
   always_ff @(posedge clock) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

/* src/r2fft_bfly.sv */
// ----------------------------------------------------------------------------
// r2fft_bfly
// Three-stage radix-2 butterfly: multiply, round, then add and saturate.
// ----------------------------------------------------------------------------
module r2fft_bfly (
   input  logic                                    clock,
   input  r2fft_pkg::work_type                     x_a,
   input  r2fft_pkg::work_type                     x_b,
   input  logic signed [r2fft_pkg::TW_WIDTH-1:0]   w_re,
   input  logic signed [r2fft_pkg::TW_WIDTH-1:0]   w_im,
   output r2fft_pkg::work_type                     y_a,
   output r2fft_pkg::work_type                     y_b
);

   localparam int PW = r2fft_pkg::WORK_WIDTH + r2fft_pkg::TW_WIDTH;
   localparam int RW = PW + 1 - 15;
   localparam int SW = RW + 1;

   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   r2fft_pkg::work_type  a1_ff, a2_ff;
   logic signed [RW-1:0] pr_ff, pi_ff;
   logic signed [PW:0]   sum_re, sum_im;
   logic signed [SW-1:0] t_a_re, t_a_im, t_b_re, t_b_im;

   function automatic logic signed [r2fft_pkg::WORK_WIDTH-1:0] sat_work(
      input logic signed [SW-1:0] v);
      logic signed [SW-1:0] hi, lo;
      hi = SW'((1 <<< (r2fft_pkg::WORK_WIDTH - 1)) - 1);
      lo = -hi - SW'(1);
      if (v > hi) begin
         return hi[r2fft_pkg::WORK_WIDTH-1:0];
      end else if (v < lo) begin
         return lo[r2fft_pkg::WORK_WIDTH-1:0];
      end
      return v[r2fft_pkg::WORK_WIDTH-1:0];
   endfunction

   // Stage one: the four partial products.
   always_ff @(posedge clock) begin
      p_rr_ff <= w_re * x_b.re;
      p_ii_ff <= w_im * x_b.im;
      p_ri_ff <= w_re * x_b.im;
      p_ir_ff <= w_im * x_b.re;
      a1_ff   <= x_a;
   end

   // Stage two: combine and round half up by 15 bits.
   always_comb begin
      sum_re = (PW+1)'(p_rr_ff) - (PW+1)'(p_ii_ff) + (PW+1)'(16384);
      sum_im = (PW+1)'(p_ri_ff) + (PW+1)'(p_ir_ff) + (PW+1)'(16384);
   end

   always_ff @(posedge clock) begin
      pr_ff <= RW'(sum_re >>> 15);
      pi_ff <= RW'(sum_im >>> 15);
      a2_ff <= a1_ff;
   end

   // Stage three: sum and difference, saturated to the working width.
   always_comb begin
      t_a_re = SW'(a2_ff.re) + SW'(pr_ff);
      t_a_im = SW'(a2_ff.im) + SW'(pi_ff);
      t_b_re = SW'(a2_ff.re) - SW'(pr_ff);
      t_b_im = SW'(a2_ff.im) - SW'(pi_ff);
   end

   always_ff @(posedge clock) begin
      y_a.re <= sat_work(t_a_re);
      y_a.im <= sat_work(t_a_im);
      y_b.re <= sat_work(t_b_re);
      y_b.im <= sat_work(t_b_im);
   end

endmodule

/* src/r2fft_scale.sv */
// ----------------------------------------------------------------------------
// r2fft_scale
// Output scaling by 1/sqrt(N) with half-up rounding and saturation.
// ----------------------------------------------------------------------------
module r2fft_scale (
   input  logic                                      clock,
   input  r2fft_pkg::work_type                       x,
   input  logic [r2fft_pkg::LG_WIDTH-1:0]            lg,
   output logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] y_re,
   output logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] y_im
);

   localparam int PW = r2fft_pkg::WORK_WIDTH + r2fft_pkg::TW_WIDTH;

   logic signed [r2fft_pkg::TW_WIDTH-1:0] coef;
   logic signed [PW-1:0]                  p_re_ff, p_im_ff;
   logic [4:0]                            shift;
   logic signed [PW:0]                    half, r_re, r_im;

   function automatic logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] sat_out(
      input logic signed [PW:0] v);
      logic signed [PW:0] hi, lo;
      hi = (PW+1)'((1 <<< (r2fft_pkg::SAMPLE_WIDTH - 1)) - 1);
      lo = -hi - (PW+1)'(1);
      if (v > hi) begin
         return hi[r2fft_pkg::SAMPLE_WIDTH-1:0];
      end else if (v < lo) begin
         return lo[r2fft_pkg::SAMPLE_WIDTH-1:0];
      end
      return v[r2fft_pkg::SAMPLE_WIDTH-1:0];
   endfunction

   // Even lengths scale by an exact power of two; odd ones add 1/sqrt(2).
   assign coef = lg[0] ? r2fft_pkg::HALF_ROOT2_Q15 : r2fft_pkg::ONE_Q15;

   always_ff @(posedge clock) begin
      p_re_ff <= coef * x.re;
      p_im_ff <= coef * x.im;
   end

   // Round half up by 15 + floor(lg/2) bits.
   always_comb begin
      shift = 5'd15 + 5'(lg >> 1);
      half  = (PW+1)'(1) <<< (shift - 5'd1);
      r_re  = ((PW+1)'(p_re_ff) + half) >>> shift;
      r_im  = ((PW+1)'(p_im_ff) + half) >>> shift;
   end

   always_ff @(posedge clock) begin
      y_re <= sat_out(r_re);
      y_im <= sat_out(r_im);
   end

endmodule

/* src/radix2_fft_unitary_core.sv */
// ----------------------------------------------------------------------------
// radix2_fft_unitary_core
// Unitary radix-2 decimation-in-time FFT of up to 64 complex Q1.15 points.
// ----------------------------------------------------------------------------
// Usage: samples are transferred on req_data when start is high and busy is
// low, one per cycle at most, and stored in natural order. The transfer that
// completes a frame of N = 2^log2_points samples raises busy. The core then
// bit-reverse permutes the frame, swapping each index with its bit-reversed
// partner when that is larger, runs N/2*log2(N) butterflies one at a time,
// each through the states ST_BF_RD, ST_BF_MUL, ST_BF_SUM, ST_BF_ADD, ST_BF_WI
// and ST_BF_WJ, using the shared butterfly unit and the single write port of
// the working store, and emits the N bins in index order, one per cycle, on
// rsp_data marked by rsp_strobe, through a read, scale multiply, and round
// and saturate pipeline. rsp_strobe lasts one cycle per bin and the receiver
// cannot hold it off. The csr_ port writes inverse (index 0) and log2_points
// (index 1); the user must write them only while the core is idle, which the
// core does not enforce. Reset clears the configuration to a forward 64-point
// transform and restarts frame loading; the working store is not cleared.
// ----------------------------------------------------------------------------
module radix2_fft_unitary_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  r2fft_pkg::req_type                       req_data,
   output logic                                     rsp_strobe,
   output r2fft_pkg::rsp_type                       rsp_data,
   input  logic                                     csr_we,
   input  logic [r2fft_pkg::CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [r2fft_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   localparam int AW = r2fft_pkg::ADDR_WIDTH;
   localparam int LW = r2fft_pkg::LG_WIDTH;
   localparam int DW = 2 * r2fft_pkg::WORK_WIDTH;

   r2fft_pkg::state_type state_ff, state_in;

   logic          inverse_ff;
   logic [LW-1:0] log2_points_ff;
   logic [LW-1:0] lg_eff, lg_ff, lg_in;
   logic [AW:0]   load_count_ff, load_count_in, load_next, n_eff;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [LW-1:0] stage_ff, stage_in;
   logic          accept;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
   r2fft_pkg::work_type ram_wdata, rdata_a, rdata_b, hold_ff, y_a, y_b, sample_w;

   logic [AW-1:0] swap_j, bf_mask, bf_i, bf_j, last_cnt, half_last;
   logic [5:0]    tw_t;
   logic signed [r2fft_pkg::TW_WIDTH-1:0] tw_re_ff, tw_im_ff;

   logic [2:0]    valid_ff;
   logic [AW-1:0] idx_ff [0:2];
   logic          last_ff [0:2];
   logic          emit_issue;
   logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] s_re, s_im;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         inverse_ff     <= 1'b0;
         log2_points_ff <= LW'(r2fft_pkg::LOG2_MAX_POINTS);
      end else if (csr_we) begin
         if (csr_index == r2fft_pkg::CSR_INVERSE) begin
            inverse_ff <= csr_wdata[0];
         end else if (csr_index == r2fft_pkg::CSR_LOG2_POINTS) begin
            log2_points_ff <= csr_wdata[LW-1:0];
         end
      end
   end

   // Effective length, clamped to the supported range.
   always_comb begin
      lg_eff = log2_points_ff;
      if (lg_eff < LW'(1)) begin
         lg_eff = LW'(1);
      end else if (lg_eff > LW'(r2fft_pkg::LOG2_MAX_POINTS)) begin
         lg_eff = LW'(r2fft_pkg::LOG2_MAX_POINTS);
      end
      n_eff = (AW+1)'(1) << lg_eff;
   end

   assign busy      = (state_ff != r2fft_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign load_next = load_count_ff + (AW+1)'(1);

   // Address generation for the permutation and the butterflies.
   always_comb begin
      swap_j    = r2fft_pkg::bit_rev(cnt_ff, lg_ff);
      bf_mask   = AW'(((AW+1)'(1) << stage_ff) - (AW+1)'(1));
      bf_i      = AW'((cnt_ff & ~bf_mask) << 1) | (cnt_ff & bf_mask);
      bf_j      = bf_i | AW'((AW+1)'(1) << stage_ff);
      tw_t      = 6'((cnt_ff & bf_mask) << (LW'(5) - stage_ff));
      last_cnt  = AW'(((AW+1)'(1) << lg_ff) - (AW+1)'(1));
      half_last = AW'(((AW+1)'(1) << (lg_ff - LW'(1))) - (AW+1)'(1));
   end

   assign sample_w.re = r2fft_pkg::WORK_WIDTH'(req_data.in_re);
   assign sample_w.im = r2fft_pkg::WORK_WIDTH'(req_data.in_im);

   // State register and sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= r2fft_pkg::ST_IDLE;
         load_count_ff <= '0;
         cnt_ff        <= '0;
         stage_ff      <= '0;
         lg_ff         <= LW'(r2fft_pkg::LOG2_MAX_POINTS);
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         cnt_ff        <= cnt_in;
         stage_ff      <= stage_in;
         lg_ff         <= lg_in;
      end
   end

   // Next state, counters and store port control.
   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      cnt_in        = cnt_ff;
      stage_in      = stage_ff;
      lg_in         = lg_ff;
      ram_we        = 1'b0;
      ram_waddr     = load_count_ff[AW-1:0];
      ram_wdata     = sample_w;
      ram_raddr_a   = cnt_ff;
      ram_raddr_b   = swap_j;
      emit_issue    = 1'b0;
      case (state_ff)
         r2fft_pkg::ST_IDLE: begin
            if (accept) begin
               ram_we = 1'b1;
               if (load_next >= n_eff) begin
                  load_count_in = '0;
                  lg_in         = lg_eff;
                  cnt_in        = '0;
                  state_in      = r2fft_pkg::ST_SWAP_RD;
               end else begin
                  load_count_in = load_next;
               end
            end
         end
         r2fft_pkg::ST_SWAP_RD: begin
            if (cnt_ff < swap_j) begin
               state_in = r2fft_pkg::ST_SWAP_W1;
            end else if (cnt_ff == last_cnt) begin
               cnt_in   = '0;
               stage_in = '0;
               state_in = r2fft_pkg::ST_BF_RD;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         r2fft_pkg::ST_SWAP_W1: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff;
            ram_wdata = rdata_b;
            state_in  = r2fft_pkg::ST_SWAP_W2;
         end
         r2fft_pkg::ST_SWAP_W2: begin
            ram_we    = 1'b1;
            ram_waddr = swap_j;
            ram_wdata = hold_ff;
            cnt_in    = cnt_ff + AW'(1);
            state_in  = r2fft_pkg::ST_SWAP_RD;
         end
         r2fft_pkg::ST_BF_RD, r2fft_pkg::ST_BF_MUL,
         r2fft_pkg::ST_BF_SUM, r2fft_pkg::ST_BF_ADD: begin
            ram_raddr_a = bf_i;
            ram_raddr_b = bf_j;
            case (state_ff)
               r2fft_pkg::ST_BF_RD:  state_in = r2fft_pkg::ST_BF_MUL;
               r2fft_pkg::ST_BF_MUL: state_in = r2fft_pkg::ST_BF_SUM;
               r2fft_pkg::ST_BF_SUM: state_in = r2fft_pkg::ST_BF_ADD;
               default:              state_in = r2fft_pkg::ST_BF_WI;
            endcase
         end
         r2fft_pkg::ST_BF_WI: begin
            ram_raddr_a = bf_i;
            ram_raddr_b = bf_j;
            ram_we      = 1'b1;
            ram_waddr   = bf_i;
            ram_wdata   = y_a;
            state_in    = r2fft_pkg::ST_BF_WJ;
         end
         r2fft_pkg::ST_BF_WJ: begin
            ram_raddr_a = bf_i;
            ram_raddr_b = bf_j;
            ram_we      = 1'b1;
            ram_waddr   = bf_j;
            ram_wdata   = y_b;
            state_in    = r2fft_pkg::ST_BF_RD;
            if (cnt_ff == half_last) begin
               cnt_in = '0;
               if (stage_ff == lg_ff - LW'(1)) begin
                  state_in = r2fft_pkg::ST_EMIT;
               end else begin
                  stage_in = stage_ff + LW'(1);
               end
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         r2fft_pkg::ST_EMIT: begin
            emit_issue = 1'b1;
            cnt_in     = cnt_ff + AW'(1);
            if (cnt_ff == last_cnt) begin
               state_in = r2fft_pkg::ST_DRAIN;
            end
         end
         r2fft_pkg::ST_DRAIN: begin
            if (valid_ff[2] && last_ff[2]) begin
               state_in = r2fft_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = r2fft_pkg::ST_IDLE;
         end
      endcase
   end

   // Swap holding register and butterfly twiddle registers.
   always_ff @(posedge clock) begin
      if (state_ff == r2fft_pkg::ST_SWAP_W1) begin
         hold_ff <= rdata_a;
      end
      if (state_ff == r2fft_pkg::ST_BF_RD) begin
         tw_re_ff <= r2fft_pkg::tw_cos(tw_t);
         tw_im_ff <= inverse_ff ? r2fft_pkg::tw_sin(tw_t) : -r2fft_pkg::tw_sin(tw_t);
      end
   end

   // Emit pipeline: read, scale multiply, round and saturate.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], emit_issue};
      end
      idx_ff[0]  <= cnt_ff;
      last_ff[0] <= (cnt_ff == last_cnt);
      for (int p = 1; p < 3; p++) begin
         idx_ff[p]  <= idx_ff[p-1];
         last_ff[p] <= last_ff[p-1];
      end
   end

   r2fft_ram #(
      .ADDR_WIDTH (AW),
      .DATA_WIDTH (DW)
   ) u_ram (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr_a (ram_raddr_a),
      .raddr_b (ram_raddr_b),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   r2fft_bfly u_bfly (
      .clock (clock),
      .x_a   (rdata_a),
      .x_b   (rdata_b),
      .w_re  (tw_re_ff),
      .w_im  (tw_im_ff),
      .y_a   (y_a),
      .y_b   (y_b)
   );

   r2fft_scale u_scale (
      .clock (clock),
      .x     (rdata_a),
      .lg    (lg_ff),
      .y_re  (s_re),
      .y_im  (s_im)
   );

   assign rsp_strobe         = valid_ff[2];
   assign rsp_data.out_re    = s_re;
   assign rsp_data.out_im    = s_im;
   assign rsp_data.bin_index = idx_ff[2];
   assign rsp_data.last_bin  = last_ff[2];

`ifndef ASSERT_OFF
   // Results only appear while a frame is being processed.
   a_strobe_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   // The final bin is followed by no further result.
   a_last_ends : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last_bin) |=> !rsp_strobe)
      else $error("result after the final bin");

   // Bins leave in order, one per cycle.
   a_bin_order : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last_bin) |=>
         (rsp_strobe && rsp_data.bin_index == $past(rsp_data.bin_index) + AW'(1)))
      else $error("bins out of order");

   // A swap always pairs an index with a larger bit-reversed partner.
   a_swap_pair : assert property (@(posedge clock) disable iff (reset)
      (state_ff == r2fft_pkg::ST_SWAP_W1) |-> (cnt_ff < swap_j))
      else $error("swap of an unordered pair");
`endif

endmodule
